### rtl/assert_macros.svh
// Assertion macros used by the top level of the LRU keyed cache.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/lkc_pkg.sv
// Package for the LRU keyed cache: size defaults, operation codes and the
// controller-to-datapath command type. No dependencies.
`default_nettype none

package lkc_pkg;

    localparam int LKC_DEPTH  = 16;
    localparam int LKC_KEY_W  = 64;
    localparam int LKC_DATA_W = 32;
    localparam int LKC_CAP_W  = 5;

    localparam logic [LKC_CAP_W-1:0] LKC_CAP_RESET = 5'd16;

    localparam logic LKC_FUNC_LOOKUP = 1'b0;
    localparam logic LKC_FUNC_INSERT = 1'b1;

    // Step strobes issued by the controller, at most one high at a time.
    typedef struct packed {
        logic capture;
        logic compare;
        logic fetch;
        logic update;
    } t_lkc_cmd;

endpackage

`default_nettype wire

### rtl/lkc_ifs.sv
// Valid/ready channel interfaces of the LRU keyed cache: request, response
// and configuration. Depends on lkc_pkg for the default widths.
`default_nettype none

interface lkc_req_if #(
    parameter int KEY_W  = lkc_pkg::LKC_KEY_W,
    parameter int DATA_W = lkc_pkg::LKC_DATA_W
);
    logic              valid;
    logic              ready;
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkc_rsp_if #(
    parameter int DATA_W = lkc_pkg::LKC_DATA_W
);
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic              evicted;
    logic [DATA_W-1:0] evicted_data;

    modport source (output valid, output hit, output read_data, output evicted,
                    output evicted_data, input ready);
    modport sink   (input valid, input hit, input read_data, input evicted,
                    input evicted_data, output ready);
endinterface

interface lkc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lkc_pkg::LKC_CAP_W-1:0]    capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### rtl/lkc_ctrl.sv
// Controller of the LRU keyed cache: sequences capture, compare, data fetch
// and update for one beat at a time, and owns the response valid flag.
// Depends on lkc_pkg.
`default_nettype none

module lkc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  wire               i_rsp_ready,
    output lkc_pkg::t_lkc_cmd o_cmd
);
    import lkc_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMPARE = 2'd1;
    localparam logic [1:0] S_FETCH   = 2'd2;
    localparam logic [1:0] S_UPDATE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_load;

    // The update step also loads the response register, so it waits while
    // an earlier response is still held and not being taken.
    assign w_load = (r_state == S_UPDATE) && (!r_out_valid || i_rsp_ready);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_req_valid;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = w_load;
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/lkc_dpath.sv
// Datapath of the LRU keyed cache: key and age registers per entry, the
// data memory, the capacity register and the response register.
// Depends on lkc_pkg.
`default_nettype none

module lkc_dpath #(
    parameter int DEPTH  = lkc_pkg::LKC_DEPTH,
    parameter int KEY_W  = lkc_pkg::LKC_KEY_W,
    parameter int DATA_W = lkc_pkg::LKC_DATA_W
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  lkc_pkg::t_lkc_cmd             i_cmd,
    input  wire                           i_func,
    input  wire  [KEY_W-1:0]              i_key,
    input  wire  [DATA_W-1:0]             i_value,
    input  wire                           i_cfg_we,
    input  wire  [lkc_pkg::LKC_CAP_W-1:0] i_cfg_capacity,
    output logic                          o_hit,
    output logic [DATA_W-1:0]             o_read_data,
    output logic                          o_evicted,
    output logic [DATA_W-1:0]             o_evicted_data
);
    import lkc_pkg::*;

    localparam int AGE_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > LKC_CAP_W) ? CNT_W : LKC_CAP_W;

    // Request held for the whole operation.
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_value;

    // Entry state. Ages of valid entries are a permutation of 0..fill-1.
    logic [DEPTH-1:0]  r_entry_valid;
    logic [KEY_W-1:0]  r_entry_key [DEPTH];
    logic [AGE_W-1:0]  r_entry_age [DEPTH];
    logic [DATA_W-1:0] r_data_mem  [DEPTH];
    logic [CNT_W-1:0]  r_fill;
    logic [LKC_CAP_W-1:0] r_capacity;

    // Compare results.
    logic [DEPTH-1:0]  r_hit_vec, r_old_vec, r_free_vec;
    logic              r_hit;
    logic [AGE_W-1:0]  r_hit_age;
    logic              r_evict_need;
    logic [DATA_W-1:0] r_rd_data;

    // Response register.
    logic              r_rsp_hit, r_rsp_evicted;
    logic [DATA_W-1:0] r_rsp_read_data, r_rsp_evicted_data;

    logic [DEPTH-1:0]  w_hit_vec, w_old_vec, w_invalid, w_free_vec, w_slot_vec;
    logic [AGE_W-1:0]  w_oldest_age, w_hit_age;
    logic [AGE_W-1:0]  w_hit_idx, w_old_idx, w_free_idx, w_slot_idx, w_rd_addr, w_wr_addr;
    logic [CMP_W-1:0]  w_cap_ext, w_fill_ext, w_eff_cap;
    logic              w_evict, w_mem_we;

    // Parallel tag compare and oldest-entry search against the fill count.
    always_comb begin
        w_oldest_age = AGE_W'(r_fill - CNT_W'(1));
        w_hit_age    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_vec[i] = r_entry_valid[i] && (r_entry_key[i] == r_key);
            w_old_vec[i] = r_entry_valid[i] && (r_entry_age[i] == w_oldest_age);
            w_invalid[i] = !r_entry_valid[i];
            w_hit_age    = w_hit_age | (w_hit_vec[i] ? r_entry_age[i] : '0);
        end
        // Lowest free entry as a one-hot vector.
        w_free_vec = w_invalid & (~w_invalid + DEPTH'(1));
    end

    always_comb begin
        w_cap_ext  = CMP_W'(r_capacity);
        w_fill_ext = CMP_W'(r_fill);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(DEPTH)) begin
            w_eff_cap = CMP_W'(DEPTH);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    // One-hot to index encoders on the registered vectors.
    always_comb begin
        w_hit_idx  = '0;
        w_old_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_idx  = w_hit_idx  | (r_hit_vec[i]  ? AGE_W'(i) : '0);
            w_old_idx  = w_old_idx  | (r_old_vec[i]  ? AGE_W'(i) : '0);
            w_free_idx = w_free_idx | (r_free_vec[i] ? AGE_W'(i) : '0);
        end
    end

    // A new key evicts when the store is at or above capacity; the freed
    // entry then takes the new key.
    assign w_evict    = (r_func == LKC_FUNC_INSERT) && !r_hit && r_evict_need;
    assign w_slot_vec = w_evict ? r_old_vec : r_free_vec;
    assign w_slot_idx = w_evict ? w_old_idx : w_free_idx;
    assign w_rd_addr  = r_hit ? w_hit_idx : w_old_idx;
    assign w_wr_addr  = r_hit ? w_hit_idx : w_slot_idx;
    assign w_mem_we   = i_cmd.update && (r_func == LKC_FUNC_INSERT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.compare) begin
            r_hit_vec    <= w_hit_vec;
            r_old_vec    <= w_old_vec;
            r_free_vec   <= w_free_vec;
            r_hit        <= |w_hit_vec;
            r_hit_age    <= w_hit_age;
            r_evict_need <= (w_fill_ext >= w_eff_cap);
        end
        if (i_cmd.update) begin
            r_rsp_hit          <= r_hit;
            r_rsp_read_data    <= ((r_func == LKC_FUNC_LOOKUP) && r_hit) ? r_rd_data : '0;
            r_rsp_evicted      <= w_evict;
            r_rsp_evicted_data <= w_evict ? r_rd_data : '0;
        end
    end

    // Data memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_data_mem[w_wr_addr] <= r_value;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_data_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (r_func == LKC_FUNC_INSERT) && !r_hit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (w_slot_vec[i]) begin
                    r_entry_key[i] <= r_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_fill        <= '0;
            r_capacity    <= LKC_CAP_RESET;
            for (int i = 0; i < DEPTH; i++) begin
                r_entry_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_capacity;
            end
            if (i_cmd.update) begin
                if (r_hit) begin
                    // Promote the hit entry; younger entries age by one.
                    for (int i = 0; i < DEPTH; i++) begin
                        if (r_hit_vec[i]) begin
                            r_entry_age[i] <= '0;
                        end else if (r_entry_valid[i] && (r_entry_age[i] < r_hit_age)) begin
                            r_entry_age[i] <= r_entry_age[i] + AGE_W'(1);
                        end
                    end
                end else if (r_func == LKC_FUNC_INSERT) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_slot_vec[i]) begin
                            r_entry_valid[i] <= 1'b1;
                            r_entry_age[i]   <= '0;
                        end else if (r_entry_valid[i]) begin
                            r_entry_age[i] <= r_entry_age[i] + AGE_W'(1);
                        end
                    end
                    if (!w_evict) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_hit          = r_rsp_hit;
    assign o_read_data    = r_rsp_read_data;
    assign o_evicted      = r_rsp_evicted;
    assign o_evicted_data = r_rsp_evicted_data;

endmodule

`default_nettype wire

### rtl/lru_keyed_cache_core.sv
// Top level of the LRU keyed cache: joins the controller and the datapath
// to the request, response and configuration channels.
// Depends on lkc_pkg, lkc_ifs, lkc_ctrl, lkc_dpath and assert_macros.svh.
//
//  Channel   Direction  Payload                                   Handshake
//  i_req     in         func, key, value                          valid/ready
//  o_rsp     out        hit, read_data, evicted, evicted_data     valid/ready
//  i_cfg     in         capacity                                  valid/ready
//
// A request beat is taken only while the controller is idle. It then passes
// through tag compare, data fetch and update, and its response is registered
// at the update step; the next beat is taken only after that update, so one
// request is handled at a time. The data fetch is a registered data memory
// read that sits between the registered tag compare and the entry update.
// Reset is synchronous and active low: it clears valid bits, ages, the fill
// count, the controller and the response flag, and sets capacity to 16; no
// clearing pass is needed. The response register holds one result: a new
// request is accepted while it waits, but the update step of that request
// stalls until the held response has been taken.
`default_nettype none
`include "assert_macros.svh"

module lru_keyed_cache_core #(
    parameter int DEPTH  = lkc_pkg::LKC_DEPTH,
    parameter int KEY_W  = lkc_pkg::LKC_KEY_W,
    parameter int DATA_W = lkc_pkg::LKC_DATA_W
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    lkc_req_if.sink   i_req,
    lkc_rsp_if.source o_rsp,
    lkc_cfg_if.sink   i_cfg
);
    import lkc_pkg::*;

    t_lkc_cmd w_cmd;
    logic     w_req_ready;
    logic     w_rsp_valid;

    lkc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    lkc_dpath #(
        .DEPTH  (DEPTH),
        .KEY_W  (KEY_W),
        .DATA_W (DATA_W)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_func         (i_req.func),
        .i_key          (i_req.key),
        .i_value        (i_req.value),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_capacity (i_cfg.capacity),
        .o_hit          (o_rsp.hit),
        .o_read_data    (o_rsp.read_data),
        .o_evicted      (o_rsp.evicted),
        .o_evicted_data (o_rsp.evicted_data)
    );

    // Capacity writes must arrive only while the block is idle; the block does
    // not enforce this. They are always taken.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_req_ready;
    assign o_rsp.valid = w_rsp_valid;

    // Only one request is in flight: acceptance leaves the idle state.
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    // An eviction only follows an insert of a key that was absent.
    `ASSERT_IMPL(a_evict_is_miss, i_clk, i_rst_n, o_rsp.valid && o_rsp.evicted, !o_rsp.hit)
    // Read data is zero unless the key was found.
    `ASSERT_IMPL(a_miss_no_data, i_clk, i_rst_n, o_rsp.valid && !o_rsp.hit, o_rsp.read_data == '0)

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lru_keyed_cache_core: a directed table, then random
// lookup and insert beats under several capacities and idling phases.
// Depends on lkc_pkg, the lkc_ifs channel interfaces and the RTL of the core.

module tb;
    import lkc_pkg::*;

    localparam int DEPTH        = LKC_DEPTH;
    localparam int KEY_W        = LKC_KEY_W;
    localparam int DATA_W       = LKC_DATA_W;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_PRINTED  = 100;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_ROWS       = 23;

    // One response beat, in the field order of the response channel.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic              evicted;
        logic [DATA_W-1:0] evicted_data;
    } t_cache_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // One row of the directed table. A request row either carries its expected
    // response (typed set) or leaves the response to the cache model below.
    // A configuration row carries only a capacity.
    typedef struct packed {
        t_row_kind         kind;
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic              typed;
        t_cache_result     want;
        logic [4:0]        capacity;
    } t_row;

    localparam t_cache_result NO_RESULT = '0;

    // The opening rows start from an empty store at the reset capacity of 16, so
    // their responses are plain: misses, fresh inserts, hits on what was just
    // written, and an insert over a present key. Later rows shrink the capacity
    // below the fill count, write zero (read as one) and 31 (read as the depth).
    localparam t_row DIRECTED [N_ROWS] = '{
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'h0, 32'h0, 1'b1, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h0, 32'hFFFF_FFFF, 1'b1, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'h0, 32'h0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 32'h0, 1'b0, 32'h0}, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h0, 32'h1234_5678, 1'b1,
          '{1'b1, 32'h0, 1'b0, 32'h0}, 5'd0},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'h0, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 32'h1234_5678, 1'b0, 32'h0}, 5'd0},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'h1, 32'h0, 1'b1, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'hA5A5_A5A5_5A5A_5A5A, 32'h3, 1'b1, NO_RESULT, 5'd0},
        '{ROW_CFG, LKC_FUNC_LOOKUP, 64'h0, 32'h0, 1'b0, NO_RESULT, 5'd1},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h5555_5555_5555_5555, 32'h7, 1'b0, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8, 1'b0, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0, NO_RESULT, 5'd0},
        '{ROW_CFG, LKC_FUNC_LOOKUP, 64'h0, 32'h0, 1'b0, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h0000_0001_0000_0000, 32'h9, 1'b0, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h0, 32'hDEAD_BEEF, 1'b0, NO_RESULT, 5'd0},
        '{ROW_CFG, LKC_FUNC_LOOKUP, 64'h0, 32'h0, 1'b0, NO_RESULT, 5'd31},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 1'b0,
          NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1, 1'b0, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'h8000_0000_0000_0000, 32'h0, 1'b0, NO_RESULT, 5'd0},
        '{ROW_REQ, LKC_FUNC_INSERT, 64'h1, 32'h8000_0000, 1'b0, NO_RESULT, 5'd0},
        '{ROW_CFG, LKC_FUNC_LOOKUP, 64'h0, 32'h0, 1'b0, NO_RESULT, 5'd16},
        '{ROW_REQ, LKC_FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 1'b0, NO_RESULT, 5'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    lkc_req_if req_ch ();
    lkc_rsp_if rsp_ch ();
    lkc_cfg_if cfg_ch ();

    lru_keyed_cache_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cache model: its own copy of the store, the ages and the capacity.
    logic              m_valid [DEPTH];
    logic [KEY_W-1:0]  m_key   [DEPTH];
    logic [DATA_W-1:0] m_data  [DEPTH];
    int unsigned       m_age   [DEPTH];
    int unsigned       m_fill;
    logic [4:0]        m_capacity;

    t_cache_result pending_results [$];

    // Expected response carried alongside the request payload for typed rows.
    logic          req_typed;
    t_cache_result req_typed_res;

    int send_idle_pct;
    int rsp_stall_pct;
    int mismatch_count;
    int quiet_cycles;

    // Entries younger than the one touched age by one; the touched one becomes
    // the most recent.
    function automatic void make_recent(int slot);
        for (int i = 0; i < DEPTH; i++) begin
            if (m_valid[i] && i != slot && m_age[i] < m_age[slot]) begin
                m_age[i]++;
            end
        end
        m_age[slot] = 0;
    endfunction

    function automatic t_cache_result cache_access(logic func, logic [KEY_W-1:0] key,
                                                   logic [DATA_W-1:0] value);
        t_cache_result res;
        int            slot;
        int            oldest;
        int unsigned   cap;
        res  = '0;
        slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot < 0 && m_valid[i] && m_key[i] == key) begin
                slot = i;
            end
        end
        if (func == LKC_FUNC_LOOKUP) begin
            if (slot >= 0) begin
                res.hit       = 1'b1;
                res.read_data = m_data[slot];
                make_recent(slot);
            end
            return res;
        end
        // An insert over a present key rewrites it in place and evicts nothing.
        if (slot >= 0) begin
            res.hit      = 1'b1;
            m_data[slot] = value;
            make_recent(slot);
            return res;
        end
        cap = (m_capacity == 0) ? 1 : (m_capacity > DEPTH) ? DEPTH : m_capacity;
        if (m_fill >= cap) begin
            oldest = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (m_valid[i] && (oldest < 0 || m_age[i] > m_age[oldest])) begin
                    oldest = i;
                end
            end
            if (oldest >= 0) begin
                res.evicted      = 1'b1;
                res.evicted_data = m_data[oldest];
                m_valid[oldest]  = 1'b0;
                m_fill--;
            end
        end
        slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot < 0 && !m_valid[i]) begin
                slot = i;
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (m_valid[i]) begin
                m_age[i]++;
            end
        end
        m_valid[slot] = 1'b1;
        m_key[slot]   = key;
        m_data[slot]  = value;
        m_age[slot]   = 0;
        m_fill++;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    // Presents one request beat from a falling edge and holds it until it is
    // taken; returns at the falling edge after the accepting rising edge.
    task automatic send_req(logic func, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value,
                            logic typed, t_cache_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.func   = func;
        req_ch.key    = key;
        req_ch.value  = value;
        req_typed     = typed;
        req_typed_res = want;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // The capacity is only written once every expected response has come back.
    task automatic write_capacity(logic [4:0] cap);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        cfg_ch.valid    = 1'b1;
        cfg_ch.capacity = cap;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // The receiver stalls at random; the new ready level is set at the falling
    // edge so that it is stable at the next rising edge.
    always @(negedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // All three channels are sampled at the rising edge. A response beat is
    // checked before a request beat of the same edge is modelled, since the
    // response always belongs to an older request.
    always @(posedge clk) begin
        t_cache_result got;
        t_cache_result want;
        t_cache_result predicted;
        logic          progress;
        if (rst_n) begin
            progress = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready) begin
                m_capacity = cfg_ch.capacity;
                progress   = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                progress = 1'b1;
                got = '{rsp_ch.hit, rsp_ch.read_data, rsp_ch.evicted, rsp_ch.evicted_data};
                if (pending_results.size() == 0) begin
                    report_mismatch("response with nothing expected",
                                    {got.read_data, got.evicted_data}, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", 64'(got.read_data),
                                        64'(want.read_data));
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
                    if (got.evicted_data !== want.evicted_data)
                        report_mismatch("evicted_data", 64'(got.evicted_data),
                                        64'(want.evicted_data));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                progress  = 1'b1;
                predicted = cache_access(req_ch.func, req_ch.key, req_ch.value);
                pending_results.push_back(req_typed ? req_typed_res : predicted);
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: too long without a beat on any channel ends the run.
    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("lru_keyed_cache_core test failed");
        $finish;
    end

    initial begin
        t_row              row;
        logic [KEY_W-1:0]  key_pool [POOL_SIZE];
        logic [KEY_W-1:0]  key;
        logic [4:0]        cap;
        int                cap_eff;
        int                span;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = LKC_FUNC_LOOKUP;
        req_ch.key      = '0;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = LKC_CAP_RESET;
        rsp_ch.ready    = 1'b1;
        req_typed       = 1'b0;
        req_typed_res   = '0;
        send_idle_pct   = 0;
        rsp_stall_pct   = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        for (int i = 0; i < DEPTH; i++) begin
            m_valid[i] = 1'b0;
            m_key[i]   = '0;
            m_data[i]  = '0;
            m_age[i]   = 0;
        end
        m_fill     = 0;
        m_capacity = LKC_CAP_RESET;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with neither side idling.
        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                write_capacity(row.capacity);
            end else begin
                send_req(row.func, row.key, row.value, row.typed, row.want);
            end
        end

        // Random part. Keys are drawn mostly from a span of a small pool a little
        // above the capacity, so that hits, rewrites and evictions all occur;
        // the rest are fresh random keys that nearly always miss.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
                default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
            endcase
            case (phase)
                0: cap = 5'd16;
                1: cap = 5'd1;
                2: cap = 5'd31;
                3: cap = 5'd0;
                4: cap = 5'($urandom_range(8, 2));
                5: cap = 5'($urandom_range(31, 0));
                6: cap = 5'($urandom_range(16, 1));
                default: cap = 5'd3;
            endcase
            write_capacity(cap);
            cap_eff = (cap == 0) ? 1 : (cap > DEPTH) ? DEPTH : int'(cap);
            span    = (cap_eff + 4 > POOL_SIZE) ? POOL_SIZE : cap_eff + 4;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 85) begin
                    key = key_pool[$urandom_range(span - 1)];
                end else begin
                    key = {$urandom, $urandom};
                end
                send_req(1'($urandom_range(1)), key, $urandom, 1'b0, NO_RESULT);
            end
        end
        req_ch.valid = 1'b0;

        // Drain, then idle for DRAIN_CYCLES so that any stray beat can show up.
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0) begin
            report_mismatch("responses still expected", 64'(pending_results.size()), '0);
        end

        if (mismatch_count == 0) begin
            $display("lru_keyed_cache_core test passed");
        end else begin
            $display("lru_keyed_cache_core test failed");
        end
        $finish;
    end

endmodule
